[sv/ptt_pkg.sv]
// Package with shared widths, codes and defaults for the periodic task timer bank.
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int unsigned MaxTasksDef = 8;
  localparam int unsigned ActiveW     = 4;
  localparam int unsigned TaskIdxW    = 3;
  localparam int unsigned TickW       = 32;
  localparam int unsigned MaskW       = 8;

  localparam logic FuncSet     = 1'b0;
  localparam logic FuncAdvance = 1'b1;

  typedef logic [TickW-1:0]    tick_t;
  typedef logic [TaskIdxW-1:0] task_idx_t;
  typedef logic [MaskW-1:0]    mask_t;
  typedef logic [ActiveW-1:0]  active_t;

endpackage

[sv/ptt_in_if.sv]
// Input channel interface of the timer bank: valid, ready and one command word.
`timescale 1ns / 1ps

interface ptt_in_if;
  import ptt_pkg::*;

  logic      valid;
  logic      ready;
  logic      func;
  task_idx_t task_index;
  tick_t     interval;
  tick_t     elapsed;

  modport source (output valid, output func, output task_index, output interval,
                  output elapsed, input ready);
  modport sink (input valid, input func, input task_index, input interval,
                input elapsed, output ready);
endinterface

[sv/ptt_out_if.sv]
// Output channel interface of the timer bank: valid, ready and one result word.
`timescale 1ns / 1ps

interface ptt_out_if;
  import ptt_pkg::*;

  logic  valid;
  logic  ready;
  mask_t fired_mask;
  tick_t min_remaining;

  modport source (output valid, output fired_mask, output min_remaining, input ready);
  modport sink (input valid, input fired_mask, input min_remaining, output ready);
endinterface

[sv/periodic_task_timer_bank.sv]
// Top level of the periodic task timer bank with its task memory and sweep control.
//
//   Channel   Direction  Handshake           Word
//   in_if     in         valid/ready         func, task_index, interval, elapsed
//   out_if    out        valid/ready         fired_mask, min_remaining
//   cfg       in         cfg_we_i only       active task count
//
// A word passes StSweep, StDrain and StFinish from acceptance to its result; the sweep
// reads live entries, where live is the active task count capped at MAX_TASKS, one per
// cycle, and the next word is accepted in the cycle after a result is loaded.
// Reset clears the control state and the per-entry valid bits; an entry that was never
// written reads as zero. A stalled result waits in the output register, and a word
// finished behind it holds until that register frees up.
`timescale 1ns / 1ps

module periodic_task_timer_bank #(
  parameter int unsigned MAX_TASKS = ptt_pkg::MaxTasksDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  ptt_pkg::active_t cfg_wdata_i,
  ptt_in_if.sink           in_if,
  ptt_out_if.source        out_if
);
  import ptt_pkg::*;

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned EntW = 2 * TickW;

  typedef enum logic [1:0] {
    StIdle,
    StSweep,
    StDrain,
    StFinish
  } state_e;

  state_e          state_q;
  active_t         active_q;
  logic [CntW-1:0] live;
  logic [CntW-1:0] rd_cnt_q;
  logic            out_valid_q;
  mask_t           out_mask_q;
  tick_t           out_min_q;

  logic [EntW-1:0] mem_q [MAX_TASKS];
  logic [MAX_TASKS-1:0] vld_q;

  logic            in_acc;
  logic            set_hit;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            rd_vld_q;
  logic            rd_hit_q;
  logic [EntW-1:0] rd_data_q;
  logic [CntW-1:0] proc_idx_q;
  logic            op_adv_q;
  tick_t           elapsed_q;

  tick_t           period;
  tick_t           count;
  tick_t           left;
  logic [TickW:0]  sum;
  logic            fire;
  tick_t           rem;

  logic            wb_en;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;

  logic            rem_vld_q;
  tick_t           rem_q;
  tick_t           min_q;
  mask_t           fired_q;

  assign in_acc  = in_if.valid && in_if.ready;
  assign set_hit = in_acc && (in_if.func == FuncSet) &&
                   (32'(in_if.task_index) < MAX_TASKS);
  assign in_if.ready = (state_q == StIdle);

  assign out_if.valid         = out_valid_q;
  assign out_if.fired_mask    = out_mask_q;
  assign out_if.min_remaining = out_min_q;

  always_comb begin
    if (32'(active_q) > MAX_TASKS) begin
      live = CntW'(MAX_TASKS);
    end else begin
      live = CntW'(active_q);
    end
  end

  assign rd_en   = (state_q == StSweep) && (rd_cnt_q != live);
  assign rd_addr = rd_cnt_q[IdxW-1:0];

  // Sweep control, output register and active count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      active_q    <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      out_mask_q  <= '0;
      out_min_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            rd_cnt_q <= '0;
            state_q  <= StSweep;
          end
        end
        StSweep: begin
          if (rd_en) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end else begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (!rd_vld_q && !rem_vld_q) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            out_mask_q  <= fired_q;
            out_min_q   <= (live == '0) ? '0 : min_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Each entry is visited once per sweep, so a write-back never meets a read of
  // the same entry, and a set write lands before the sweep's first read.
  always_comb begin
    period = rd_hit_q ? rd_data_q[EntW-1:TickW] : '0;
    count  = rd_hit_q ? rd_data_q[TickW-1:0] : '0;
    left   = period - count;
    sum    = {1'b0, count} + {1'b0, elapsed_q};
    fire   = op_adv_q && (sum >= {1'b0, period});
    if (fire) begin
      rem = period;
    end else if (op_adv_q) begin
      rem = period - sum[TickW-1:0];
    end else begin
      rem = left;
    end
  end

  assign wb_en   = rd_vld_q && op_adv_q;
  assign wr_en   = set_hit || wb_en;
  assign wr_addr = set_hit ? IdxW'(in_if.task_index) : proc_idx_q[IdxW-1:0];
  assign wr_data = set_hit ? {in_if.interval, {TickW{1'b0}}}
                           : {period, (fire ? {TickW{1'b0}} : sum[TickW-1:0])};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_hit_q  <= 1'b0;
      rem_vld_q <= 1'b0;
      op_adv_q  <= 1'b0;
      fired_q   <= '0;
      min_q     <= '1;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rd_vld_q  <= rd_en;
      rd_hit_q  <= vld_q[rd_addr];
      rem_vld_q <= rd_vld_q;
      if (in_acc) begin
        op_adv_q <= (in_if.func == FuncAdvance);
        fired_q  <= '0;
        min_q    <= '1;
      end else begin
        if (rd_vld_q && fire) begin
          for (int j = 0; j < MaskW; j++) begin
            if (32'(proc_idx_q) == 32'(j)) begin
              fired_q[j] <= 1'b1;
            end
          end
        end
        if (rem_vld_q && (rem_q < min_q)) begin
          min_q <= rem_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q <= rd_cnt_q;
    rem_q      <= rem;
    if (in_acc) begin
      elapsed_q <= in_if.elapsed;
    end
  end

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish) && (!out_valid_q || out_if.ready) |=> out_valid_q)
    else $error("finished result was not presented");

  a_wb_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_en |-> (state_q == StSweep) || (state_q == StDrain))
    else $error("write-back outside a sweep");

  a_rem_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_vld_q |-> $past(rd_vld_q))
    else $error("remaining time without a preceding read");

  a_set_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_hit |=> vld_q[$past(wr_addr)])
    else $error("set word did not mark its entry valid");

  a_set_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) && !op_adv_q |-> (fired_q == '0))
    else $error("set word produced a fired bit");

endmodule
